// File: hw/rtl/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
package pli_pkg;

  localparam int DATA_W          = 32;
  localparam int MAX_POINTS_DEF  = 64;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        [1:0]        opcode;
    logic signed [DATA_W-1:0] sample_time;
    logic signed [DATA_W-1:0] sample_value;
    logic signed [DATA_W-1:0] query_time;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interpolated_value;
    logic        [1:0]        status;
  } rsp_t;

  // One stored breakpoint.
  typedef struct packed {
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] v;
  } point_t;

  // Segment handed to the divide/multiply unit.
  typedef struct packed {
    logic signed [DATA_W-1:0] q;
    logic signed [DATA_W-1:0] t0;
    logic signed [DATA_W-1:0] t1;
    logic signed [DATA_W-1:0] v0;
    logic signed [DATA_W-1:0] v1;
  } seg_t;

endpackage

// File: hw/rtl/pli_store.sv
// Breakpoint memory: one write port, one registered read port.
module pli_store #(
  parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  pli_pkg::point_t       wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output pli_pkg::point_t       rdata
);

  pli_pkg::point_t mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pli_divmul.sv
// Iterative unit: restoring divide for the fraction, folded Horner multiply by dv.
module pli_divmul #(
  parameter int FRAC_BITS = pli_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  pli_pkg::seg_t                      seg,
  output logic                               done,
  output logic signed [pli_pkg::DATA_W-1:0]  value
);

  localparam int W     = pli_pkg::DATA_W;
  localparam int CW    = (FRAC_BITS > 0) ? $clog2(FRAC_BITS + 1) : 1;
  localparam int ACC_W = W + FRAC_BITS + 2;

  logic                    run;
  logic [CW-1:0]           cnt;
  logic [W-1:0]            rem;
  logic [W-1:0]            span;
  logic signed [W:0]       dv;
  logic signed [W-1:0]     v0;
  logic signed [ACC_W-1:0] acc;

  logic [W:0]              rem_dbl;
  logic                    ge;
  logic [W:0]              rem_sub;
  logic [W-1:0]            rem_next;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] acc_shr;
  logic [W:0]              dt_full;
  logic [W:0]              span_full;

  assign dt_full   = {seg.q[W-1], seg.q} - {seg.t0[W-1], seg.t0};
  assign span_full = {seg.t1[W-1], seg.t1} - {seg.t0[W-1], seg.t0};

  // One quotient bit a cycle, MSB first; each set bit adds dv into the shifted product.
  assign rem_dbl  = {rem, 1'b0};
  assign ge       = rem_dbl >= {1'b0, span};
  assign rem_sub  = rem_dbl - {1'b0, span};
  assign rem_next = ge ? rem_sub[W-1:0] : rem_dbl[W-1:0];
  assign acc_next = (acc <<< 1) + (ge ? ACC_W'(dv) : ACC_W'(0));
  assign acc_shr  = acc >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        run  <= 1'b1;
        done <= 1'b0;
        cnt  <= CW'(FRAC_BITS);
        rem  <= dt_full[W-1:0];
        span <= span_full[W-1:0];
        dv   <= {seg.v1[W-1], seg.v1} - {seg.v0[W-1], seg.v0};
        v0   <= seg.v0;
        acc  <= '0;
      end else if (run) begin
        if (cnt == '0) begin
          run   <= 1'b0;
          done  <= 1'b1;
          value <= v0 + acc_shr[W-1:0];
        end else begin
          done <= 1'b0;
          cnt  <= cnt - CW'(1);
          rem  <= rem_next;
          acc  <= acc_next;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/piecewise_linear_interpolator.sv
// Top level: breakpoint table with search sequencer and interpolation unit.
//
//   channel   ports                  transfer
//   request   start, busy, request   start high while busy low
//   result    done, result           done high for one cycle, always taken
//
// Clear, append, unused codes and a query on an empty table finish one cycle
// after the transfer. A query reads breakpoints one a cycle through the single
// memory read port and, when a segment holds the query, hands that segment to the
// divide/multiply unit and waits for its done. The table is not cleared by reset;
// only the point count is. No stall on the result side.
module piecewise_linear_interpolator #(
  parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = pli_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pli_pkg::req_t  request,
  output logic           done,
  output pli_pkg::rsp_t  result
);

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int W      = pli_pkg::DATA_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SCAN,
    S_INTERP
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [ADDR_W-1:0]     idx;
  logic signed [W-1:0]   q;
  pli_pkg::point_t       prev;
  logic                  ge_prev;

  logic                  we;
  logic [ADDR_W-1:0]     raddr;
  pli_pkg::point_t       rdata;
  pli_pkg::point_t       wdata;
  logic [CNT_W-1:0]      last_cnt;
  logic [ADDR_W-1:0]     last_idx;
  logic [ADDR_W-1:0]     idx_inc;
  logic                  lt;
  logic                  eq;
  logic                  div_start;
  logic                  div_done;
  logic signed [W-1:0]   div_value;
  pli_pkg::seg_t         seg;

  assign busy     = (state != S_IDLE);
  assign last_cnt = count - CNT_W'(1);
  assign last_idx = last_cnt[ADDR_W-1:0];
  assign idx_inc  = idx + ADDR_W'(1);

  // Shared less-than and equal compares of the query time against the breakpoint just read.
  assign lt = q < rdata.t;
  assign eq = q == rdata.t;

  assign we = (state == S_IDLE) && start && (request.opcode == pli_pkg::OP_APPEND)
              && (count != CNT_W'(MAX_POINTS));
  assign wdata.t = request.sample_time;
  assign wdata.v = request.sample_value;

  assign div_start = (state == S_SCAN) && ge_prev && lt;
  assign seg.q  = q;
  assign seg.t0 = prev.t;
  assign seg.t1 = rdata.t;
  assign seg.v0 = prev.v;
  assign seg.v1 = rdata.v;

  always_comb begin
    unique case (state)
      S_CHK_FIRST: raddr = last_idx;
      S_CHK_LAST:  raddr = ADDR_W'(1);
      S_SCAN:      raddr = idx_inc;
      default:     raddr = '0;
    endcase
  end

  pli_store #(
    .MAX_POINTS (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  pli_divmul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divmul (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .seg   (seg),
    .done  (div_done),
    .value (div_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            result.interpolated_value <= '0;
            unique case (request.opcode)
              pli_pkg::OP_CLEAR: begin
                count         <= '0;
                result.status <= pli_pkg::ST_OK;
                done          <= 1'b1;
              end
              pli_pkg::OP_APPEND: begin
                if (count == CNT_W'(MAX_POINTS)) begin
                  result.status <= pli_pkg::ST_FULL;
                end else begin
                  count         <= count + CNT_W'(1);
                  result.status <= pli_pkg::ST_OK;
                end
                done <= 1'b1;
              end
              pli_pkg::OP_QUERY: begin
                if (count == '0) begin
                  result.status <= pli_pkg::ST_EMPTY;
                  done          <= 1'b1;
                end else begin
                  // entry 0 is being read this cycle
                  done  <= 1'b0;
                  q     <= request.query_time;
                  state <= S_CHK_FIRST;
                end
              end
              default: begin
                result.status <= pli_pkg::ST_OK;
                done          <= 1'b1;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_CHK_FIRST: begin
          if (lt || eq) begin
            result.interpolated_value <= rdata.v;
            result.status             <= pli_pkg::ST_OK;
            done                      <= 1'b1;
            state                     <= S_IDLE;
          end else begin
            done    <= 1'b0;
            prev    <= rdata;
            ge_prev <= 1'b1;
            state   <= S_CHK_LAST;
          end
        end
        S_CHK_LAST: begin
          if (!lt) begin
            result.interpolated_value <= rdata.v;
            result.status             <= pli_pkg::ST_OK;
            done                      <= 1'b1;
            state                     <= S_IDLE;
          end else begin
            done  <= 1'b0;
            idx   <= ADDR_W'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ge_prev && lt) begin
            done  <= 1'b0;
            state <= S_INTERP;
          end else if (idx == last_idx) begin
            // unordered table: no segment holds the query
            result.interpolated_value <= '0;
            result.status             <= pli_pkg::ST_OK;
            done                      <= 1'b1;
            state                     <= S_IDLE;
          end else begin
            done    <= 1'b0;
            prev    <= rdata;
            ge_prev <= !lt;
            idx     <= idx_inc;
          end
        end
        S_INTERP: begin
          if (div_done) begin
            result.interpolated_value <= div_value;
            result.status             <= pli_pkg::ST_OK;
            done                      <= 1'b1;
            state                     <= S_IDLE;
          end else begin
            done <= 1'b0;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
